// ===== rtl/ietfr_pkg.sv =====
// package: constants, atan table and small arithmetic helpers for the frame rotation
package ietfr_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam logic [31:0] RATE_RESET = 32'd80177662;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    function automatic logic signed [33:0] atan_val(input int i);
        logic signed [33:0] r;
        case (i)
            0: r = 34'sd536870912;
            1: r = 34'sd316933406;
            2: r = 34'sd167458907;
            3: r = 34'sd85004756;
            4: r = 34'sd42667331;
            5: r = 34'sd21354465;
            6: r = 34'sd10679838;
            7: r = 34'sd5340245;
            8: r = 34'sd2670163;
            9: r = 34'sd1335087;
            10: r = 34'sd667544;
            11: r = 34'sd333772;
            12: r = 34'sd166886;
            13: r = 34'sd83443;
            14: r = 34'sd41722;
            15: r = 34'sd20861;
            16: r = 34'sd10430;
            17: r = 34'sd5215;
            18: r = 34'sd2608;
            19: r = 34'sd1304;
            20: r = 34'sd652;
            21: r = 34'sd326;
            22: r = 34'sd163;
            23: r = 34'sd81;
            24: r = 34'sd41;
            25: r = 34'sd20;
            26: r = 34'sd10;
            27: r = 34'sd5;
            28: r = 34'sd3;
            29: r = 34'sd1;
            30: r = 34'sd1;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -40'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/ietfr_cordic.sv =====
// pipelined rotation-mode cordic: one stage per register, cosine and sine in q.30
module ietfr_cordic (
    input  logic                aclk,
    input  logic                en,
    input  logic [31:0]         angle,
    output logic signed [33:0]  cos_q30,
    output logic signed [33:0]  sin_q30
);
    import ietfr_pkg::*;

    logic signed [33:0] x_reg [CORDIC_STAGES+1];
    logic signed [33:0] y_reg [CORDIC_STAGES+1];
    logic signed [33:0] z_reg [CORDIC_STAGES+1];
    logic               n_reg [CORDIC_STAGES+1];
    logic               neg_in;
    logic [31:0]        red;

    // fold the angle into the right half plane
    assign neg_in = angle[31] ^ angle[30];
    assign red    = neg_in ? angle + 32'h80000000 : angle;

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= CORDIC_GAIN;
            y_reg[0] <= '0;
            z_reg[0] <= {{2{red[31]}}, red};
            n_reg[0] <= neg_in;
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!z_reg[i][33]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_val(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_val(i);
                end
                n_reg[i+1] <= n_reg[i];
            end
        end
    end

    assign cos_q30 = n_reg[CORDIC_STAGES] ? -x_reg[CORDIC_STAGES] : x_reg[CORDIC_STAGES];
    assign sin_q30 = n_reg[CORDIC_STAGES] ? -y_reg[CORDIC_STAGES] : y_reg[CORDIC_STAGES];
endmodule

// ===== rtl/inertial_to_fixed_frame_rotation.sv =====
// top level: streaming inertial to planet-fixed rotation of position and velocity
// Takes one state vector per clock and returns one result per clock while the
// output is not stalled; the cordic pipeline is followed by registers for the
// products, rounding, rate term and saturation. The whole pipeline advances
// when the output register is empty or taken, so a stall holds every stage.
// rotation_rate is q.40 rad/s, reset to earth; write it only while idle.
module inertial_to_fixed_frame_rotation (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // hour_angle, pos_x_in, pos_y_in, pos_z_in, vel_x_in, vel_y_in, vel_z_in
    input  logic [223:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x_out, pos_y_out, pos_z_out, vel_x_out, vel_y_out, vel_z_out
    output logic [191:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data
);
    import ietfr_pkg::*;

    localparam int LAT = CORDIC_STAGES + 1;
    localparam int DEPTH = LAT + 6;

    logic [31:0] rate_reg;
    logic        en;
    logic [DEPTH-1:0] vld_reg;

    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = vld_reg[DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= RATE_RESET;
            vld_reg  <= '0;
        end else begin
            if (cfg_valid) begin
                rate_reg <= cfg_data;
            end
            if (en) begin
                vld_reg <= {vld_reg[DEPTH-2:0], s_tvalid};
            end
        end
    end

    logic signed [33:0] c, s;

    ietfr_cordic u_cordic (
        .aclk   (aclk),
        .en     (en),
        .angle  (s_tdata[31:0]),
        .cos_q30(c),
        .sin_q30(s)
    );

    // delay line for the linear fields alongside the cordic
    logic [191:0] d_reg [LAT];
    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg[0] <= s_tdata[223:32];
            for (int k = 1; k < LAT; k++) begin
                d_reg[k] <= d_reg[k-1];
            end
        end
    end

    logic signed [31:0] px, py, pz, vx, vy, vz;
    assign px = d_reg[LAT-1][31:0];
    assign py = d_reg[LAT-1][63:32];
    assign pz = d_reg[LAT-1][95:64];
    assign vx = d_reg[LAT-1][127:96];
    assign vy = d_reg[LAT-1][159:128];
    assign vz = d_reg[LAT-1][191:160];

    // stage a: eight products
    logic signed [65:0] pxc_reg, pys_reg, pyc_reg, pxs_reg;
    logic signed [65:0] vxc_reg, vys_reg, vyc_reg, vxs_reg;
    logic [63:0]        zpass_a_reg;
    // stage b: sums and rounding
    logic signed [35:0] rx_reg, ry_reg, ux_reg, uy_reg;
    logic [63:0]        zpass_b_reg;
    // stage c: rate products, split in 16-bit halves of the rate
    logic signed [52:0] ahx_reg, alx_reg, ahy_reg, aly_reg;
    logic signed [35:0] rx_c_reg, ry_c_reg, ux_c_reg, uy_c_reg;
    logic [63:0]        zpass_c_reg;
    // stage d: rate terms
    logic signed [39:0] tx_reg, ty_reg;
    logic signed [35:0] rx_d_reg, ry_d_reg, ux_d_reg, uy_d_reg;
    logic [63:0]        zpass_d_reg;
    // stage e: velocity sums
    logic signed [39:0] vox_reg, voy_reg;
    logic signed [35:0] rx_e_reg, ry_e_reg;
    logic [63:0]        zpass_e_reg;
    logic [191:0]       out_reg;

    logic signed [66:0] sum_px, sum_py, sum_vx, sum_vy;
    logic signed [52:0] qy, qx;
    logic signed [16:0] rhi, rlo;

    assign rhi = {1'b0, rate_reg[31:16]};
    assign rlo = {1'b0, rate_reg[15:0]};
    assign sum_px = pxc_reg + pys_reg + 67'sd536870912;
    assign sum_py = pyc_reg - pxs_reg + 67'sd536870912;
    assign sum_vx = vxc_reg + vys_reg + 67'sd536870912;
    assign sum_vy = vyc_reg - vxs_reg + 67'sd536870912;
    assign qy = (aly_reg + 53'sd536870912) >>> 16;
    assign qx = (alx_reg + 53'sd536870912) >>> 16;

    logic signed [52:0] ty_full, tx_full;
    assign ty_full = (ahy_reg + qy) >>> 14;
    assign tx_full = (ahx_reg + qx) >>> 14;

    always_ff @(posedge aclk) begin
        if (en) begin
            pxc_reg <= px * c;
            pys_reg <= py * s;
            pyc_reg <= py * c;
            pxs_reg <= px * s;
            vxc_reg <= vx * c;
            vys_reg <= vy * s;
            vyc_reg <= vy * c;
            vxs_reg <= vx * s;
            zpass_a_reg <= {vz, pz};

            rx_reg <= 36'(sum_px >>> 30);
            ry_reg <= 36'(sum_py >>> 30);
            ux_reg <= 36'(sum_vx >>> 30);
            uy_reg <= 36'(sum_vy >>> 30);
            zpass_b_reg <= zpass_a_reg;

            ahy_reg <= 53'(ry_reg * rhi);
            aly_reg <= 53'(ry_reg * rlo);
            ahx_reg <= 53'(rx_reg * rhi);
            alx_reg <= 53'(rx_reg * rlo);
            rx_c_reg <= rx_reg;
            ry_c_reg <= ry_reg;
            ux_c_reg <= ux_reg;
            uy_c_reg <= uy_reg;
            zpass_c_reg <= zpass_b_reg;

            ty_reg <= 40'(ty_full);
            tx_reg <= 40'(tx_full);
            rx_d_reg <= rx_c_reg;
            ry_d_reg <= ry_c_reg;
            ux_d_reg <= ux_c_reg;
            uy_d_reg <= uy_c_reg;
            zpass_d_reg <= zpass_c_reg;

            vox_reg <= 40'(ux_d_reg) + ty_reg;
            voy_reg <= 40'(uy_d_reg) - tx_reg;
            rx_e_reg <= rx_d_reg;
            ry_e_reg <= ry_d_reg;
            zpass_e_reg <= zpass_d_reg;

            out_reg <= {zpass_e_reg[63:32], sat32(voy_reg), sat32(vox_reg),
                        zpass_e_reg[31:0], sat32(40'(ry_e_reg)), sat32(40'(rx_e_reg))};
        end
    end

    assign m_tdata = out_reg;
endmodule

// ===== tb/frame_rotation_checker.sv =====
// checker: predicts the planet-fixed state vector for each request and compares results
`timescale 1ns / 100ps

module frame_rotation_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [223:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [191:0] m_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [31:0]  cfg_data,
    output int           fail_count,
    output int           pending_count,
    output int           result_count
);
    import ietfr_pkg::*;

    typedef struct packed {
        logic signed [31:0] vel_z;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] pos_z;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
    } fixed_state_t;

    logic [31:0] spin_rate;
    fixed_state_t fixed_queue[$];

    function automatic longint shr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint round_q30(longint v);
        return shr(v + (64'sd1 <<< 29), 30);
    endfunction

    // spin rate times rotated position, split to keep the product in 64 bits
    function automatic longint spin_term(logic [31:0] w, longint p);
        longint hi, lo, q;
        hi = p * longint'({16'd0, w[31:16]});
        lo = p * longint'({16'd0, w[15:0]});
        q = shr(lo + (64'sd1 <<< 29), 16);
        return shr(hi + q, 14);
    endfunction

    function automatic fixed_state_t rotate_to_fixed(logic [223:0] d, logic [31:0] w);
        logic [31:0] ang;
        logic flip;
        longint x, y, z, nx, c, s, px, py, vx, vy, rx, ry, ux, uy, t;
        fixed_state_t r;
        ang = d[31:0];
        flip = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
        if (flip) ang = ang + 32'h80000000;
        x = 652032874;
        y = 0;
        z = longint'(signed'(ang));
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            t = (i < 31) ? atan_val(i) : 0;
            if (z >= 0) begin
                nx = x - shr(y, i);
                y = y + shr(x, i);
                z = z - t;
            end else begin
                nx = x + shr(y, i);
                y = y - shr(x, i);
                z = z + t;
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
        px = longint'(signed'(d[63:32]));
        py = longint'(signed'(d[95:64]));
        vx = longint'(signed'(d[159:128]));
        vy = longint'(signed'(d[191:160]));
        rx = round_q30(px * c + py * s);
        ry = round_q30(py * c - px * s);
        ux = round_q30(vx * c + vy * s) + spin_term(w, ry);
        uy = round_q30(vy * c - vx * s) - spin_term(w, rx);
        r.pos_x = clamp32(rx);
        r.pos_y = clamp32(ry);
        r.pos_z = d[127:96];
        r.vel_x = clamp32(ux);
        r.vel_y = clamp32(uy);
        r.vel_z = d[223:192];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    assign pending_count = fixed_queue.size();

    always @(posedge aclk) begin
        fixed_state_t want, got;
        if (!aresetn) begin
            spin_rate <= RATE_RESET;
            fixed_queue.delete();
            fail_count = 0;
            result_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) spin_rate <= cfg_data;
            if (s_tvalid && s_tready) fixed_queue.push_back(rotate_to_fixed(s_tdata, spin_rate));
            if (m_tvalid && m_tready) begin
                result_count <= result_count + 1;
                got = m_tdata;
                if (fixed_queue.size() == 0) begin
                    report_mismatch("unexpected result", got.pos_x, 32'd0);
                end else begin
                    want = fixed_queue.pop_front();
                    if (got.pos_x !== want.pos_x) report_mismatch("pos_x", got.pos_x, want.pos_x);
                    if (got.pos_y !== want.pos_y) report_mismatch("pos_y", got.pos_y, want.pos_y);
                    if (got.pos_z !== want.pos_z) report_mismatch("pos_z", got.pos_z, want.pos_z);
                    if (got.vel_x !== want.vel_x) report_mismatch("vel_x", got.vel_x, want.vel_x);
                    if (got.vel_y !== want.vel_y) report_mismatch("vel_y", got.vel_y, want.vel_y);
                    if (got.vel_z !== want.vel_z) report_mismatch("vel_z", got.vel_z, want.vel_z);
                end
            end
        end
    end
endmodule

// ===== tb/testbench.sv =====
// testbench top: stimulus, rate register phases and verdict for the frame rotation
`timescale 1ns / 100ps

module testbench;
    import ietfr_pkg::*;

    localparam int DRAIN_CYCLES = 64;
    localparam int STALL_LIMIT = 5000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [223:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [191:0] m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [31:0]  cfg_data = '0;
    int           fail_count, pending_count, result_count;
    int           idle_cycles = 0;
    bit           calm = 1'b0;
    int           request_count = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    inertial_to_fixed_frame_rotation uut (.*);

    frame_rotation_checker checker_i (.*);

    // receiver stalls a quarter of the time except during the calm stretch
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 25);
    end

    // watchdog on cycles with no accepted request or result
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 3) - 1;
            3: return $urandom() >>> $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    task automatic send_request(logic [223:0] d);
        if (!calm) begin
            while ($urandom_range(0, 99) < 25) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        request_count++;
    endtask

    task automatic settle_and_write(logic [31:0] w);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= w;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_burst(int n);
        logic [223:0] d;
        for (int k = 0; k < n; k++) begin
            for (int f = 0; f < 7; f++) d[f*32 +: 32] = pick_word();
            // mostly realistic orbit magnitudes, rest full range
            if ($urandom_range(0, 3) != 0)
                for (int f = 1; f < 7; f++)
                    d[f*32 +: 32] = $signed($urandom()) >>> $urandom_range(6, 12);
            calm = (k >= n / 3) && (k < n / 3 + 40);
            send_request(d);
        end
        calm = 1'b0;
    endtask

    initial begin
        logic [223:0] d;
        logic [31:0] angles[8];
        angles = '{32'h0, 32'h3fffffff, 32'h40000000, 32'h7fffffff,
                   32'h80000000, 32'hbfffffff, 32'hc0000000, 32'hffffffff};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // quadrant boundaries with plain vectors, then extreme magnitudes
        foreach (angles[i]) begin
            d = {32'sd1048576, -32'sd7340032, 32'sd7864320,
                 32'sd1024, -32'sd6800000, 32'sd7000000, angles[i]};
            send_request(d);
        end
        for (int i = 0; i < 8; i++) begin
            for (int f = 1; f < 7; f++)
                d[f*32 +: 32] = ((i + f) % 2) ? 32'h7fffffff : 32'h80000000;
            d[31:0] = angles[i] ^ 32'h12345678;
            send_request(d);
        end
        d = '0;
        send_request(d);
        d = '1;
        send_request(d);
        random_burst(120);
        settle_and_write(32'hffffffff);
        random_burst(90);
        settle_and_write(32'd0);
        random_burst(90);
        settle_and_write(32'd77935760);
        random_burst(80);
        settle_and_write(RATE_RESET);
        random_burst(20);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d state vectors, %0d results, quadrant edges and saturation",
                 request_count, result_count);
        $display("rate register set to maximum, zero, mars and earth between phases");
        if (fail_count == 0 && pending_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule
